// ===== rtl/core/pst_pkg.sv =====
// Shared types, widths and constants of the pressure spline tessellator.
`timescale 1ns / 1ps
package pst_pkg;

  localparam int CoordW   = 16;
  localparam int PressW   = 16;
  localparam int SpacingW = 8;
  localparam int StepW    = 5;
  localparam int AddrW    = 3;
  localparam int DataW    = 32;

  localparam int KW   = 13;               // k * spacing, at most 31 * 255
  localparam int DistW = 2 * KW + 1;      // squared length
  localparam int BW   = 18;               // basis weights
  localparam int BIW  = 21;               // basis intermediates
  localparam int PW   = BW + CoordW;      // weight times coordinate
  localparam int SW   = PW + 2;           // four-term sum
  localparam int QW   = CoordW + 1;       // quotient bits
  localparam int DenW = 16;               // 2 * n^3
  localparam int PnW  = 24;               // pressure numerator
  localparam int PdW  = StepW + 1;        // 2 * n

  localparam logic [StepW-1:0] MaxSteps = StepW'(31);
  localparam logic [StepW-1:0] MinSteps = StepW'(2);
  localparam logic [PressW-1:0] PressMin = PressW'(1638);
  localparam logic [PressW-1:0] PressMax = PressW'(32768);
  localparam logic [SpacingW-1:0] SpacingReset = SpacingW'(24);
  localparam logic [StepW-1:0] LimitReset = StepW'(31);

  localparam logic RegSpacing = 1'b0;
  localparam logic RegLimit   = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] pt_x;
    logic signed [CoordW-1:0] pt_y;
    logic [PressW-1:0]        pt_pressure;
    logic                     final_point;
  } pt_t;

  typedef struct packed {
    logic signed [CoordW-1:0] smp_x;
    logic signed [CoordW-1:0] smp_y;
    logic [PressW-1:0]        smp_pressure;
    logic                     run_end;
    logic                     stroke_end;
  } smp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_SEG_INIT, S_SEG_W1, S_SEG_W2, S_SEG_W3, S_STEPS,
    S_SA, S_SB, S_SC, S_SD, S_SE, S_DIV_GO, S_DIV_WAIT, S_EMIT, S_FINAL, S_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic seg_init;
    logic seg_end;
    logic steps_init;
    logic steps_iter;
    logic s_inc;
    logic div_start;
    logic emit_sample;
    logic emit_final;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] ps;
    logic       fin;
    logic       steps_found;
    logic       s_last;
    logic       div_done;
    logic       out_free;
  } stat_t;

  function automatic logic [PressW-1:0] clamp_press(input logic [QW-1:0] p);
    logic [PressW-1:0] r;
    if (p < QW'(PressMin)) r = PressMin;
    else if (p > QW'(PressMax)) r = PressMax;
    else r = p[PressW-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/pressure_spline_tessellator_top.sv =====
// Top level of the pressure spline tessellator: register port, sequencer, datapath.
//
// Usage: stroke points enter on in_valid/in_ready as one in_data word (x, y in
// Q12.4, pressure in Q1.15, final_point). Samples leave on out_valid/out_ready as
// out_data words; run_end marks the last word caused by a point and stroke_end
// the final unchanged point of a stroke. sample_spacing (address 0) and
// step_limit (address 4) are written over the APB-style port while idle.
// One point is taken at a time. Each segment passes through its set-up states
// and the step search, then computes each sample with the 17-step restoring
// dividers for x, y and pressure running in parallel.
// A point that closes a stroke adds a closing segment (when the window holds a point) and one final word.
// A new point is accepted once the last word of the previous one sits in the
// output register, even while the receiver stalls. When the receiver holds
// out_ready low, the next sample is computed and then waits for the register.
// Reset (synchronous, active high) clears the point window and restores the
// register defaults (spacing 24, step limit 31).
`timescale 1ns / 1ps
module pressure_spline_tessellator_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pst_pkg::pt_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pst_pkg::smp_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pst_pkg::AddrW-1:0]   paddr,
  input  logic [pst_pkg::DataW-1:0]   pwdata,
  output logic [pst_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import pst_pkg::*;

  logic [SpacingW-1:0] spacing;
  logic [StepW-1:0]    limit;
  cmd_t                cmd;
  stat_t               stat;
  logic                wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= SpacingReset;
      limit   <= LimitReset;
    end else if (wr) begin
      if (paddr[2] == RegSpacing) spacing <= pwdata[SpacingW-1:0];
      else limit <= pwdata[StepW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegLimit) ? DataW'(limit) : DataW'(spacing);

  pst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  pst_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_data(in_data),
    .spacing(spacing), .limit(limit), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sample || cmd.emit_final) |-> stat.out_free)
    else $error("word loaded over a pending output");
  a_stroke_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.stroke_end) |-> out_data.run_end)
    else $error("stroke end without run end");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second point taken while busy");
`endif

endmodule

// ===== rtl/core/pst_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pst_div #(
  parameter int NW = 36,
  parameter int DW = 16,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          done
);
  localparam int CntW = $clog2(QW + 1);

  logic [NW-1:0]   rem;
  logic [NW-1:0]   dsh;
  logic [CntW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CntW'(QW);
    end else if (cnt != '0) begin
      cnt <= cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= NW'(den) << (QW - 1);
      quo <= '0;
    end else if (cnt != '0) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        quo <= {quo[QW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign done = (cnt == '0);

endmodule

// ===== rtl/core/pst_datapath.sv =====
// Point window, step search, spline and pressure arithmetic, output register.
`timescale 1ns / 1ps
module pst_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  pst_pkg::cmd_t                 cmd,
  output pst_pkg::stat_t                stat,
  input  pst_pkg::pt_t                  in_data,
  input  logic [pst_pkg::SpacingW-1:0]  spacing,
  input  logic [pst_pkg::StepW-1:0]     limit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pst_pkg::smp_t                 out_data
);
  import pst_pkg::*;

  localparam logic signed [QW:0] CHi = (QW + 1)'(2 ** (CoordW - 1) - 1);
  localparam logic signed [QW:0] CLo = -CHi - (QW + 1)'(1);

  // window and new point
  logic signed [CoordW-1:0] wx [3];
  logic signed [CoordW-1:0] wy [3];
  logic [PressW-1:0]        wp [3];
  logic [1:0]               ps;
  logic signed [CoordW-1:0] nx, ny;
  logic [PressW-1:0]        np;
  logic                     fin;

  // segment control points
  logic signed [CoordW-1:0] sx [4];
  logic signed [CoordW-1:0] sy [4];
  logic [PressW-1:0]        pa, pb;

  // step search
  logic [StepW-1:0]     cap, cap_c;
  logic [KW-1:0]        lim;
  logic signed [CoordW:0] ddx, ddy;
  logic [CoordW:0]      adx, ady;
  logic                 ovf;
  logic [KW-1:0]        axs, ays;
  logic [2*KW-1:0]      sqx, sqy, kk2;
  logic [DistW-1:0]     len_sq;
  logic [StepW-1:0]     k, n, s;
  logic [KW-1:0]        kk;
  logic                 found;

  // sample chain
  logic [2*StepW-1:0]   s2, n2, sn;
  logic [3*StepW-1:0]   s3, s2n, sn2, n3;
  logic signed [BIW-1:0] is3, is2n, isn2, in3, b0, b1, b2, b3;
  logic signed [BW-1:0] bw [4];
  logic signed [PW-1:0] prx [4];
  logic signed [PW-1:0] pry [4];
  logic [20:0]          pna;
  logic signed [21:0]   pnb;
  logic signed [16:0]   pdiff;
  logic [DenW-1:0]      den;
  logic signed [SW-1:0] sumx, sumy;
  logic [SW-1:0]        mx, my;
  logic                 negx, negy;
  logic signed [PnW-1:0] pt;
  logic [PnW-1:0]       pm;
  logic [QW-1:0]        qx, qy, qp;
  logic                 dxd, dyd, dpd;
  logic signed [QW:0]   vx, vy;
  logic [CoordW-1:0]    rx, ry;
  logic [PressW-1:0]    np_c;

  assign np_c = clamp_press(QW'(in_data.pt_pressure));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      nx  <= in_data.pt_x;
      ny  <= in_data.pt_y;
      np  <= np_c;
      fin <= in_data.final_point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ps <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        wx[i] <= '0;
        wy[i] <= '0;
        wp[i] <= '0;
      end
    end else if (cmd.commit) begin
      if (ps == 2'd0) begin
        for (int i = 0; i < 3; i++) begin
          wx[i] <= nx;
          wy[i] <= ny;
          wp[i] <= np;
        end
      end else begin
        for (int i = 0; i < 2; i++) begin
          wx[i] <= wx[i+1];
          wy[i] <= wy[i+1];
          wp[i] <= wp[i+1];
        end
        wx[2] <= nx;
        wy[2] <= ny;
        wp[2] <= np;
      end
      if (fin) ps <= 2'd0;
      else if (ps != 2'd3) ps <= ps + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_init) begin
      if (cmd.seg_end) begin
        sx[0] <= wx[1]; sx[1] <= wx[2]; sx[2] <= nx; sx[3] <= nx;
        sy[0] <= wy[1]; sy[1] <= wy[2]; sy[2] <= ny; sy[3] <= ny;
        pa <= wp[2];
        pb <= np;
      end else begin
        sx[0] <= wx[0]; sx[1] <= wx[1]; sx[2] <= wx[2]; sx[3] <= nx;
        sy[0] <= wy[0]; sy[1] <= wy[1]; sy[2] <= wy[2]; sy[3] <= ny;
        pa <= wp[1];
        pb <= wp[2];
      end
    end
  end

  // step count: smallest k from 2 with (k*spacing)^2 >= length^2, at most the clamped step limit
  always_comb begin
    if (limit < MinSteps) cap_c = MinSteps;
    else if (limit > MaxSteps) cap_c = MaxSteps;
    else cap_c = limit;
  end

  assign ddx = (CoordW + 1)'(sx[2]) - (CoordW + 1)'(sx[1]);
  assign ddy = (CoordW + 1)'(sy[2]) - (CoordW + 1)'(sy[1]);
  assign adx = ddx[CoordW] ? (CoordW + 1)'(-ddx) : (CoordW + 1)'(ddx);
  assign ady = ddy[CoordW] ? (CoordW + 1)'(-ddy) : (CoordW + 1)'(ddy);
  assign kk2 = kk * kk;
  assign found = ovf || ({1'b0, kk2} >= len_sq) || (k == cap);

  always_ff @(posedge clk) begin
    cap    <= cap_c;
    lim    <= KW'(cap) * KW'(spacing);
    ovf    <= (adx > (CoordW + 1)'(lim)) || (ady > (CoordW + 1)'(lim));
    axs    <= adx[KW-1:0];
    ays    <= ady[KW-1:0];
    sqx    <= axs * axs;
    sqy    <= ays * ays;
    len_sq <= DistW'(sqx) + DistW'(sqy);
  end

  always_ff @(posedge clk) begin
    if (cmd.steps_init) begin
      k  <= MinSteps;
      kk <= KW'({spacing, 1'b0});
    end else if (cmd.steps_iter && !found) begin
      k  <= k + StepW'(1);
      kk <= kk + KW'(spacing);
    end
    if (cmd.steps_iter && found) begin
      n <= ovf ? cap : k;
      s <= '0;
    end else if (cmd.s_inc) begin
      s <= s + StepW'(1);
    end
  end

  // basis weights and products, a register after each step
  assign is3  = $signed(BIW'(s3));
  assign is2n = $signed(BIW'(s2n));
  assign isn2 = $signed(BIW'(sn2));
  assign in3  = $signed(BIW'(n3));
  assign b0 = -is3 + (is2n <<< 1) - isn2;
  assign b1 = (is3 <<< 1) + is3 - (is2n <<< 2) - is2n + (in3 <<< 1);
  assign b2 = -(is3 <<< 1) - is3 + (is2n <<< 2) + isn2;
  assign b3 = is3 - is2n;
  assign pdiff = $signed({1'b0, pb}) - $signed({1'b0, pa});
  assign den = {n3, 1'b0};

  assign sumx = SW'(prx[0]) + SW'(prx[1]) + SW'(prx[2]) + SW'(prx[3])
              + $signed(SW'(n3));
  assign sumy = SW'(pry[0]) + SW'(pry[1]) + SW'(pry[2]) + SW'(pry[3])
              + $signed(SW'(n3));
  assign pt = $signed(PnW'(pna)) + PnW'(pnb);

  always_ff @(posedge clk) begin
    s2  <= s * s;
    n2  <= n * n;
    sn  <= s * n;
    s3  <= (3 * StepW)'(s2) * (3 * StepW)'(s);
    s2n <= (3 * StepW)'(s2) * (3 * StepW)'(n);
    sn2 <= (3 * StepW)'(sn) * (3 * StepW)'(n);
    n3  <= (3 * StepW)'(n2) * (3 * StepW)'(n);
    bw[0] <= b0[BW-1:0];
    bw[1] <= b1[BW-1:0];
    bw[2] <= b2[BW-1:0];
    bw[3] <= b3[BW-1:0];
    for (int i = 0; i < 4; i++) begin
      prx[i] <= PW'(bw[i]) * PW'(sx[i]);
      pry[i] <= PW'(bw[i]) * PW'(sy[i]);
    end
    pna  <= 21'(pa) * 21'(n);
    pnb  <= 22'(pdiff) * $signed(22'(s));
    negx <= sumx[SW-1];
    negy <= sumy[SW-1];
    // floor for negative numerators: -floor((-N + D - 1) / D)
    mx   <= sumx[SW-1] ? (~sumx + SW'(den)) : sumx;
    my   <= sumy[SW-1] ? (~sumy + SW'(den)) : sumy;
    pm   <= {pt[PnW-2:0], 1'b0} + PnW'(n);
  end

  pst_div #(.NW(SW), .DW(DenW), .QW(QW)) u_div_x (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(mx), .den(den),
    .quo(qx), .done(dxd)
  );

  pst_div #(.NW(SW), .DW(DenW), .QW(QW)) u_div_y (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(my), .den(den),
    .quo(qy), .done(dyd)
  );

  pst_div #(.NW(PnW), .DW(PdW), .QW(QW)) u_div_p (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(pm), .den({n, 1'b0}),
    .quo(qp), .done(dpd)
  );

  assign vx = negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign vy = negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

  always_comb begin
    if (vx > CHi) rx = CHi[CoordW-1:0];
    else if (vx < CLo) rx = CLo[CoordW-1:0];
    else rx = vx[CoordW-1:0];
    if (vy > CHi) ry = CHi[CoordW-1:0];
    else if (vy < CLo) ry = CLo[CoordW-1:0];
    else ry = vy[CoordW-1:0];
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sample || cmd.emit_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sample) begin
      out_data.smp_x        <= rx;
      out_data.smp_y        <= ry;
      out_data.smp_pressure <= clamp_press(qp);
      out_data.run_end      <= (s == n - StepW'(1)) && !fin;
      out_data.stroke_end   <= 1'b0;
    end else if (cmd.emit_final) begin
      out_data.smp_x        <= nx;
      out_data.smp_y        <= ny;
      out_data.smp_pressure <= np;
      out_data.run_end      <= 1'b1;
      out_data.stroke_end   <= 1'b1;
    end
  end

  assign stat.ps          = ps;
  assign stat.fin         = fin;
  assign stat.steps_found = found;
  assign stat.s_last      = (s == n - StepW'(1));
  assign stat.div_done    = dxd && dyd && dpd;
  assign stat.out_free    = !out_valid || out_ready;

endmodule

// ===== rtl/core/pst_ctrl.sv =====
// Sequencer: segments, step search, per-sample arithmetic and output hand-off.
`timescale 1ns / 1ps
module pst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pst_pkg::stat_t stat,
  output pst_pkg::cmd_t  cmd
);
  import pst_pkg::*;

  state_t state, state_next;
  logic   seg_end, seg_end_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      seg_end <= 1'b0;
    end else begin
      state   <= state_next;
      seg_end <= seg_end_next;
    end
  end

  always_comb begin
    state_next   = state;
    seg_end_next = seg_end;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.ps == 2'd0) begin
          state_next = stat.fin ? S_FINAL : S_COMMIT;
        end else if (stat.ps == 2'd1) begin
          seg_end_next = 1'b1;
          state_next   = stat.fin ? S_SEG_INIT : S_COMMIT;
        end else begin
          seg_end_next = 1'b0;
          state_next   = S_SEG_INIT;
        end
      end
      S_SEG_INIT: begin
        cmd.seg_init = 1'b1;
        cmd.seg_end  = seg_end;
        state_next   = S_SEG_W1;
      end
      S_SEG_W1: state_next = S_SEG_W2;
      S_SEG_W2: state_next = S_SEG_W3;
      S_SEG_W3: begin
        cmd.steps_init = 1'b1;
        state_next     = S_STEPS;
      end
      S_STEPS: begin
        cmd.steps_iter = 1'b1;
        if (stat.steps_found) state_next = S_SA;
      end
      S_SA: state_next = S_SB;
      S_SB: state_next = S_SC;
      S_SC: state_next = S_SD;
      S_SD: state_next = S_SE;
      S_SE: state_next = S_DIV_GO;
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_sample = 1'b1;
          if (!stat.s_last) begin
            cmd.s_inc  = 1'b1;
            state_next = S_SA;
          end else if (!seg_end && stat.fin) begin
            seg_end_next = 1'b1;
            state_next   = S_SEG_INIT;
          end else if (seg_end) begin
            state_next = S_FINAL;
          end else begin
            state_next = S_COMMIT;
          end
        end
      end
      S_FINAL: begin
        if (stat.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
